FILE: rtl/ctaocc_pkg.sv
// Package for the resident-block occupancy block.
// Holds field widths, payload structs, divider lane type and the shared divider step.
package ctaocc_pkg;

   localparam int WARP_LANES = 32;

   localparam int CORE_W = 9;
   localparam int TPC_W  = 13;
   localparam int SBPC_W = 19;
   localparam int RPC_W  = 19;
   localparam int BLIM_W = 7;

   localparam int THR_W  = 11;
   localparam int SMEM_W = 19;
   localparam int REG_W  = 8;
   localparam int GRID_W = 32;

   localparam int BPC_W  = 7;
   localparam int STAT_W = 2;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 19;

   localparam int PAD_W  = 12;
   localparam int R4_W   = 9;
   localparam int DEN_W  = PAD_W + R4_W;
   localparam int REM_W  = 41;
   localparam int QUO_W  = 7;
   localparam int STEPS  = QUO_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CORE_COUNT  = 3'd0,
      CSR_THREADS     = 3'd1,
      CSR_SHARED      = 3'd2,
      CSR_REGISTERS   = 3'd3,
      CSR_BLOCK_LIMIT = 3'd4
   } csr_idx_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_EXCEEDS  = 2'd1,
      STAT_ZERO_THR = 2'd2
   } status_type;

   typedef struct packed {
      logic [THR_W-1:0]  block_threads;
      logic [SMEM_W-1:0] block_shared_bytes;
      logic [REG_W-1:0]  thread_registers;
      logic [GRID_W-1:0] grid_blocks;
   } req_type;

   typedef struct packed {
      logic [BPC_W-1:0]  blocks_per_core;
      logic [STAT_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [CORE_W-1:0] core_count;
      logic [TPC_W-1:0]  threads_per_core;
      logic [SBPC_W-1:0] shared_bytes_per_core;
      logic [RPC_W-1:0]  registers_per_core;
      logic [BLIM_W-1:0] blocks_per_core_limit;
   } cfg_type;

   // one saturating quotient in flight
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             sat;
   } lane_type;

   typedef struct packed {
      logic              zero_thr;
      logic              use_smem;
      logic              use_regs;
      logic              use_grid;
      logic [GRID_W-1:0] grid;
      logic [CORE_W-1:0] cores;
      lane_type          thr;
      lane_type          smem;
      lane_type          regs;
      lane_type          gridq;
   } work_type;

   // Saturation check (sat_step) or one restoring quotient bit at position sh.
   function automatic lane_type div_step(lane_type x, logic [2:0] sh, logic sat_step);
      logic [REM_W-1:0] dsh;
      lane_type         y;
      dsh = {{(REM_W-DEN_W){1'b0}}, x.den} << sh;
      y   = x;
      if (x.rem >= dsh) begin
         if (sat_step) begin
            y.sat = 1'b1;
         end else begin
            y.rem     = x.rem - dsh;
            y.quo[sh] = 1'b1;
         end
      end
      return y;
   endfunction

   function automatic logic [QUO_W-1:0] lane_q(lane_type x);
      return x.sat ? {QUO_W{1'b1}} : x.quo;
   endfunction

endpackage

FILE: rtl/ctaocc_front.sv
// Front end: registers a query, pads it to warps and builds the divider operands.
// Depends on ctaocc_pkg.
module ctaocc_front import ctaocc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  cfg_type  cfg,
   output logic     push,
   output work_type push_data,
   input  logic     q_full
);

   logic    vld_ff, vld_in;
   req_type req_ff;
   logic    take;

   logic [PAD_W-1:0]  padded;
   logic [R4_W-1:0]   r4;
   logic [DEN_W-1:0]  rden;
   logic [GRID_W:0]   gnum;

   assign req_stall = vld_ff && q_full;
   assign push      = vld_ff && !q_full;
   assign take      = req_valid && !req_stall;
   assign vld_in    = take || (vld_ff && q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (take) begin
         req_ff <= req_data;
      end
   end

   always_comb begin
      padded = PAD_W'((({1'b0, req_ff.block_threads} + PAD_W'(WARP_LANES - 1)) / WARP_LANES)
               * WARP_LANES);
      r4     = (R4_W'(req_ff.thread_registers) + R4_W'(3)) & ~R4_W'(3);
      rden   = DEN_W'(padded) * DEN_W'(r4);
      // ceiling of grid over cores, as floor of (grid + cores - 1)
      gnum   = {1'b0, req_ff.grid_blocks} + (GRID_W+1)'(cfg.core_count)
               - (GRID_W+1)'(1);

      push_data          = '0;
      push_data.zero_thr = (req_ff.block_threads == '0);
      push_data.use_smem = (req_ff.block_shared_bytes != '0);
      push_data.use_regs = (req_ff.thread_registers != '0);
      push_data.use_grid = (cfg.core_count != '0);
      push_data.grid     = req_ff.grid_blocks;
      push_data.cores    = cfg.core_count;
      push_data.thr.rem   = REM_W'(cfg.threads_per_core);
      push_data.thr.den   = DEN_W'(padded);
      push_data.smem.rem  = REM_W'(cfg.shared_bytes_per_core);
      push_data.smem.den  = DEN_W'(req_ff.block_shared_bytes);
      push_data.regs.rem  = REM_W'(cfg.registers_per_core);
      push_data.regs.den  = rden;
      push_data.gridq.rem = REM_W'(gnum);
      push_data.gridq.den = DEN_W'(cfg.core_count);
   end

endmodule

FILE: rtl/ctaocc_fifo.sv
// Short queue between front and back end.
// Depends on ctaocc_pkg.
module ctaocc_fifo import ctaocc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output work_type pop_data
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   work_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0]   cnt_ff;
   logic             do_pop;

   assign full     = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + PTR_W'(1);
         if (do_pop) rd_ff <= rd_ff + PTR_W'(1);
         cnt_ff <= cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/ctaocc_back.sv
// Back end: four saturating divider lanes (a saturation stage, then one quotient bit per stage), then min and grid fit.
// Depends on ctaocc_pkg.
module ctaocc_back import ctaocc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  work_type q_data,
   output logic     q_pop,
   input  cfg_type  cfg,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   work_type st_ff  [STEPS+1];
   logic     vld_ff [STEPS+1];
   work_type st_in  [STEPS+1];
   logic     en;
   logic     out_vld_ff;
   rsp_type  out_ff, out_in;

   logic [QUO_W-1:0]       res;
   logic [QUO_W+CORE_W-1:0] fill;
   work_type               fin;

   assign en        = !(out_vld_ff && rsp_stall);
   assign q_pop     = en;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic [2:0] sh;
      st_in[0] = q_data;
      for (int j = 0; j < STEPS; j++) begin
         sh = (j == 0) ? 3'd7 : 3'(7 - j);
         st_in[j+1]       = st_ff[j];
         st_in[j+1].thr   = div_step(st_ff[j].thr,   sh, j == 0);
         st_in[j+1].smem  = div_step(st_ff[j].smem,  sh, j == 0);
         st_in[j+1].regs  = div_step(st_ff[j].regs,  sh, j == 0);
         st_in[j+1].gridq = div_step(st_ff[j].gridq, sh, j == 0);
      end
   end

   always_comb begin
      fin = st_ff[STEPS];
      res = lane_q(fin.thr);
      if (fin.use_smem && lane_q(fin.smem) < res) res = lane_q(fin.smem);
      if (fin.use_regs && lane_q(fin.regs) < res) res = lane_q(fin.regs);
      if (cfg.blocks_per_core_limit < res) res = cfg.blocks_per_core_limit;
      fill = (QUO_W+CORE_W)'(res) * (QUO_W+CORE_W)'(fin.cores);
      // grid too small to fill every core: share it out, rounded up
      if (fin.use_grid && fin.grid < GRID_W'(fill)) res = lane_q(fin.gridq);
      if (fin.zero_thr) begin
         out_in.blocks_per_core = '0;
         out_in.status          = STAT_ZERO_THR;
      end else if (res == '0) begin
         out_in.blocks_per_core = '0;
         out_in.status          = STAT_EXCEEDS;
      end else begin
         out_in.blocks_per_core = res;
         out_in.status          = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= STEPS; j++) vld_ff[j] <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= !q_empty;
         for (int j = 0; j < STEPS; j++) vld_ff[j+1] <= vld_ff[j];
         out_vld_ff <= vld_ff[STEPS];
      end
      if (en) begin
         for (int j = 0; j <= STEPS; j++) st_ff[j] <= st_in[j];
         out_ff <= out_in;
      end
   end

endmodule

FILE: rtl/cta_occupancy_limit_core.sv
// Resident-block occupancy per core for kernel launch queries.
// Throughput: one query per cycle unless the result beat is stalled or the queue is full;
// the eight-stage divider lanes set the latency.
// Reset (synchronous): configuration returns to 16 cores, 2048 threads, 49152 bytes,
// 65536 registers, cap 32; all queued and in-flight queries are dropped.
module cta_occupancy_limit_core import ctaocc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     push, q_full, q_pop, q_empty;
   work_type push_data, q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.core_count            <= CORE_W'(16);
         cfg_ff.threads_per_core      <= TPC_W'(2048);
         cfg_ff.shared_bytes_per_core <= SBPC_W'(49152);
         cfg_ff.registers_per_core    <= RPC_W'(65536);
         cfg_ff.blocks_per_core_limit <= BLIM_W'(32);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CORE_COUNT:  cfg_ff.core_count            <= csr_wdata[CORE_W-1:0];
            CSR_THREADS:     cfg_ff.threads_per_core      <= csr_wdata[TPC_W-1:0];
            CSR_SHARED:      cfg_ff.shared_bytes_per_core <= csr_wdata[SBPC_W-1:0];
            CSR_REGISTERS:   cfg_ff.registers_per_core    <= csr_wdata[RPC_W-1:0];
            CSR_BLOCK_LIMIT: cfg_ff.blocks_per_core_limit <= csr_wdata[BLIM_W-1:0];
            default: ;
         endcase
      end
   end

   ctaocc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   ctaocc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   ctaocc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/ctaocc_checker.sv
// Port-level checker for the occupancy block, bound to the top level.
// Depends on ctaocc_pkg.
module ctaocc_checker import ctaocc_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status == STAT_OK || rsp_data.status == STAT_EXCEEDS
                    || rsp_data.status == STAT_ZERO_THR)
      else $error("undefined status code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STAT_OK |-> rsp_data.blocks_per_core == '0)
      else $error("error status with nonzero block count");

   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_OK |-> rsp_data.blocks_per_core != '0)
      else $error("ok status with zero block count");

   a_no_out_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind cta_occupancy_limit_core ctaocc_checker u_ctaocc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: tb/tb_cta_occupancy_limit_core.sv
// Testbench for cta_occupancy_limit_core: random and directed occupancy queries.
// Depends on ctaocc_pkg; predicts each result locally and checks beats in order.
module tb_cta_occupancy_limit_core;
   import ctaocc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   cta_occupancy_limit_core DUT (.*);

   cfg_type   occ_cfg;
   req_type   query_q[$];
   rsp_type   occupancy_q[$];
   int        errors;
   int        idle_cycles;
   int        gap_left;
   int        hold_left;
   bit        hold_done;
   bit        phase_busy;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int short_or_long_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // occupancy from the current configuration
   function automatic rsp_type predict_occupancy(req_type q);
      rsp_type   r;
      bit [63:0] padded, res, r4;
      r.blocks_per_core = '0;
      if (q.block_threads == 0) begin
         r.status = STAT_ZERO_THR;
         return r;
      end
      padded = ((64'(q.block_threads) + WARP_LANES - 1) / WARP_LANES) * WARP_LANES;
      res = 64'(occ_cfg.threads_per_core) / padded;
      if (q.block_shared_bytes != 0 &&
          64'(occ_cfg.shared_bytes_per_core) / q.block_shared_bytes < res)
         res = 64'(occ_cfg.shared_bytes_per_core) / q.block_shared_bytes;
      if (q.thread_registers != 0) begin
         r4 = (64'(q.thread_registers) + 3) & ~64'd3;
         if (64'(occ_cfg.registers_per_core) / (padded * r4) < res)
            res = 64'(occ_cfg.registers_per_core) / (padded * r4);
      end
      if (64'(occ_cfg.blocks_per_core_limit) < res) res = 64'(occ_cfg.blocks_per_core_limit);
      if (occ_cfg.core_count != 0 && 64'(q.grid_blocks) < res * occ_cfg.core_count)
         res = (64'(q.grid_blocks) + occ_cfg.core_count - 1) / occ_cfg.core_count;
      if (res < 1) begin
         r.status = STAT_EXCEEDS;
      end else begin
         r.blocks_per_core = res[BPC_W-1:0];
         r.status = STAT_OK;
      end
      return r;
   endfunction

   function automatic req_type random_query();
      req_type q;
      int      k;
      k = $urandom_range(0, 9);
      q.block_threads = (k == 0) ? THR_W'($urandom) : THR_W'($urandom_range(1, 1024));
      case ($urandom_range(0, 3))
         0: q.block_shared_bytes = '0;
         1: q.block_shared_bytes = SMEM_W'($urandom);
         default: q.block_shared_bytes = SMEM_W'($urandom_range(1, 16384));
      endcase
      q.thread_registers = ($urandom_range(0, 4) == 0) ? '0 : REG_W'($urandom);
      case ($urandom_range(0, 3))
         0: q.grid_blocks = $urandom;
         1: q.grid_blocks = $urandom_range(0, 300);
         default: q.grid_blocks = $urandom_range(0, 20000);
      endcase
      return q;
   endfunction

   // driver: present queued beats with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid && !req_stall) query_q.delete(0);
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (query_q.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= query_q[0];
            gap_left  <= short_or_long_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict at acceptance so configuration in effect is the one applied
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         occupancy_q.insert(occupancy_q.size(), predict_occupancy(req_data));
   end

   // receiver stall and result check
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (occupancy_q.size() == 0) begin
               $display("%0t: unexpected beat %p", $realtime, rsp_data);
               errors++;
            end else begin
               e = occupancy_q[0];
               occupancy_q.delete(0);
               if (rsp_data.blocks_per_core !== e.blocks_per_core)
                  begin
                  $display("%0t: blocks_per_core expected %0d actual %0d", $realtime,
                           e.blocks_per_core, rsp_data.blocks_per_core);
                  errors++;
               end
               if (rsp_data.status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           e.status, rsp_data.status);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (!hold_done && phase_busy && query_q.size() > 200) begin
            hold_left <= 300;
            hold_done <= 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (short_or_long_gap() != 0) && ($urandom_range(0, 1) == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CORE_COUNT:  occ_cfg.core_count = val[CORE_W-1:0];
         CSR_THREADS:     occ_cfg.threads_per_core = val[TPC_W-1:0];
         CSR_SHARED:      occ_cfg.shared_bytes_per_core = val[SBPC_W-1:0];
         CSR_REGISTERS:   occ_cfg.registers_per_core = val[RPC_W-1:0];
         CSR_BLOCK_LIMIT: occ_cfg.blocks_per_core_limit = val[BLIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (query_q.size() != 0 || req_valid || occupancy_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_query(logic [THR_W-1:0] t, logic [SMEM_W-1:0] s,
                            logic [REG_W-1:0] r, logic [GRID_W-1:0] g);
      req_type q;
      q.block_threads = t;
      q.block_shared_bytes = s;
      q.thread_registers = r;
      q.grid_blocks = g;
      query_q.insert(query_q.size(), q);
   endtask

   initial begin
      int ph;
      errors = 0;
      phase_busy = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      occ_cfg.core_count = 16;
      occ_cfg.threads_per_core = 2048;
      occ_cfg.shared_bytes_per_core = 49152;
      occ_cfg.registers_per_core = 65536;
      occ_cfg.blocks_per_core_limit = 32;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero threads, extremes, empty grid, oversized block, partial grid
      add_query(0, 100, 32, 1000);
      add_query(11'h7FF, 0, 0, 32'hFFFF_FFFF);
      add_query(1, 0, 0, 32'hFFFF_FFFF);
      add_query(1024, 0, 0, 32'hFFFF_FFFF);
      add_query(1024, 19'h7FFFF, 255, 0);
      add_query(256, 1, 1, 1);
      add_query(33, 49152, 3, 100000);
      add_query(64, 49153, 4, 100000);
      add_query(128, 4096, 255, 100000);
      add_query(32, 0, 255, 17);
      add_query(32, 0, 0, 0);
      add_query(500, 3000, 40, 33);
      add_query(2047, 1, 1, 1);
      wait_drained();

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: ;
            1: begin
               write_reg(CSR_CORE_COUNT, 0);
               write_reg(CSR_THREADS, 4096);
               write_reg(CSR_SHARED, 262144);
               write_reg(CSR_REGISTERS, 262144);
               write_reg(CSR_BLOCK_LIMIT, 64);
            end
            2: begin
               write_reg(CSR_CORE_COUNT, 1);
               write_reg(CSR_THREADS, 32);
               write_reg(CSR_SHARED, 1);
               write_reg(CSR_REGISTERS, 1);
               write_reg(CSR_BLOCK_LIMIT, 1);
            end
            3: begin
               write_reg(CSR_CORE_COUNT, 256);
               write_reg(CSR_THREADS, 13'h1FFF);
               write_reg(CSR_SHARED, 19'h7FFFF);
               write_reg(CSR_REGISTERS, 19'h7FFFF);
               write_reg(CSR_BLOCK_LIMIT, 7'h7F);
            end
            4: begin
               write_reg(CSR_CORE_COUNT, 511);
               write_reg(CSR_THREADS, 0);
               write_reg(CSR_BLOCK_LIMIT, 0);
               write_reg(csr_idx_type'(3'd6), 5);
            end
            default: begin
               write_reg(CSR_CORE_COUNT, CSR_DAT_W'($urandom_range(0, 511)));
               write_reg(CSR_THREADS, CSR_DAT_W'($urandom_range(0, 8191)));
               write_reg(CSR_SHARED, CSR_DAT_W'($urandom_range(0, 19'h7FFFF)));
               write_reg(CSR_REGISTERS, CSR_DAT_W'($urandom_range(0, 19'h7FFFF)));
               write_reg(CSR_BLOCK_LIMIT, CSR_DAT_W'($urandom_range(0, 127)));
            end
         endcase
         phase_busy = (ph == 0);
         repeat ((ph == 0) ? 400 : 110) query_q.insert(query_q.size(), random_query());
         wait_drained();
      end

      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
